// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// signal must hold low whenever the condition holds
`define ASSERT_NEVER(lbl, cond, sig, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> !(sig)) else $error(msg);

`endif

// ===== hdl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// types, codes and the digit character function shared by the radix formatter modules
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_PREP,
		ST_PAD_PRE,
		ST_SIGN,
		ST_DIGIT,
		ST_PAD_POST
	} state_t;

	typedef enum logic [1:0] {
		SEL_PAD,
		SEL_SIGN,
		SEL_DIGIT
	} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      div_step;
		logic      push;
		logic      prep;
		logic      emit;
		char_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic bit_last;
		logic quot_zero;
		logic pad_zero;
		logic has_sign;
		logic left;
		logic dig_one;
		logic out_free;
	} status_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		begin
			if (d < 4'd10) begin
				c = 8'h30 + {4'h0, d};
			end else if (lower) begin
				c = 8'h61 + {4'h0, d} - 8'd10;
			end else begin
				c = 8'h41 + {4'h0, d} - 8'd10;
			end
			return c;
		end
	endfunction

endpackage

// ===== hdl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer: division loop, digit pushes, then pad / sign / digit / trailing pad emission
// ----------------------------------------------------------------------------
module itoa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  itoa_pkg::status_t st,
	output itoa_pkg::cmd_t    cmd
);
	import itoa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (st.bit_last) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				state_d = st.quot_zero ? ST_PREP : ST_DIV;
			end
			ST_PREP: begin
				state_d = st.left ? ST_SIGN : ST_PAD_PRE;
			end
			ST_PAD_PRE: begin
				if (st.pad_zero) state_d = ST_SIGN;
			end
			ST_SIGN: begin
				if (!st.has_sign || st.out_free) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (st.out_free && st.dig_one) state_d = st.left ? ST_PAD_POST : ST_IDLE;
			end
			ST_PAD_POST: begin
				if (st.pad_zero) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '{load: 1'b0, div_step: 1'b0, push: 1'b0, prep: 1'b0,
			emit: 1'b0, sel: SEL_PAD};
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_PUSH: cmd.push = 1'b1;
			ST_PREP: cmd.prep = 1'b1;
			ST_PAD_PRE, ST_PAD_POST: begin
				cmd.sel  = SEL_PAD;
				cmd.emit = st.out_free && !st.pad_zero;
			end
			ST_SIGN: begin
				cmd.sel  = SEL_SIGN;
				cmd.emit = st.out_free && st.has_sign;
			end
			ST_DIGIT: begin
				cmd.sel  = SEL_DIGIT;
				cmd.emit = st.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/itoa_dp.sv =====
// ----------------------------------------------------------------------------
// itoa_dp
// datapath: bit-serial division by the radix, digit stack, counters and
// the output register
// ----------------------------------------------------------------------------
module itoa_dp #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_WIDTH  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [55:0]       s_tdata,
	input  itoa_pkg::cmd_t    cmd,
	output itoa_pkg::status_t st,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);
	import itoa_pkg::*;

	localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int DW = $clog2(VALUE_BITS + 1);

	// unpacked input fields
	logic                  in_op;
	logic [31:0]           in_value;
	logic [4:0]            in_radix;
	logic                  in_lower;
	logic                  in_plus;
	logic                  in_left;
	logic [6:0]            in_width;
	logic [7:0]            in_pad;
	logic [63:0]           value_ext;
	logic [VALUE_BITS-1:0] raw;
	logic                  neg;

	assign in_op     = s_tdata[0];
	assign in_value  = s_tdata[32:1];
	assign in_radix  = s_tdata[37:33];
	assign in_lower  = s_tdata[38];
	assign in_plus   = s_tdata[39];
	assign in_left   = s_tdata[40];
	assign in_width  = s_tdata[47:41];
	assign in_pad    = s_tdata[55:48];
	assign value_ext = {32'h0, in_value};
	assign raw       = value_ext[VALUE_BITS-1:0];
	assign neg       = in_op && raw[VALUE_BITS-1];

	logic [VALUE_BITS-1:0] mag_q;
	logic [3:0]            rem_q;
	logic [BW-1:0]         bcnt_q;
	logic [3:0]            stk_q [VALUE_BITS];
	logic [DW-1:0]         ndig_q;
	logic [4:0]            radix_q;
	logic                  lower_q;
	logic                  left_q;
	logic                  has_sign_q;
	logic                  neg_q;
	logic [6:0]            width_q;
	logic [7:0]            pad_q;
	logic [6:0]            npad_q;
	logic [6:0]            tot_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	// one restoring division step
	logic [4:0] trial;
	logic       ge;
	logic [4:0] trial_sub;
	assign trial     = {rem_q, mag_q[VALUE_BITS-1]};
	assign ge        = trial >= radix_q;
	assign trial_sub = trial - radix_q;

	// field length and padding
	logic [6:0] len;
	assign len = 7'(ndig_q) + {6'h0, has_sign_q};

	logic [7:0] char_d;
	always_comb begin
		unique case (cmd.sel)
			SEL_PAD:   char_d = pad_q;
			SEL_SIGN:  char_d = neg_q ? ASCII_MINUS : ASCII_PLUS;
			SEL_DIGIT: char_d = digit_char(stk_q[0], lower_q);
			default:   char_d = pad_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q      <= neg ? (~raw + VALUE_BITS'(1)) : raw;
			rem_q      <= '0;
			bcnt_q     <= '0;
			ndig_q     <= '0;
			lower_q    <= in_lower;
			left_q     <= in_left;
			neg_q      <= neg;
			has_sign_q <= neg || in_plus;
			pad_q      <= in_pad;
			width_q    <= (in_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : in_width;
			if (in_radix < 5'd2) begin
				radix_q <= 5'd2;
			end else if (in_radix > 5'd16) begin
				radix_q <= 5'd16;
			end else begin
				radix_q <= in_radix;
			end
		end
		if (cmd.div_step) begin
			mag_q  <= {mag_q[VALUE_BITS-2:0], ge};
			rem_q  <= ge ? trial_sub[3:0] : trial[3:0];
			bcnt_q <= bcnt_q + BW'(1);
		end
		// digits arrive least significant first, so the top digit ends at index 0
		if (cmd.push) begin
			stk_q[0] <= rem_q;
			for (int i = 1; i < VALUE_BITS; i++) stk_q[i] <= stk_q[i-1];
			ndig_q <= ndig_q + DW'(1);
			rem_q  <= '0;
			bcnt_q <= '0;
		end
		if (cmd.prep) begin
			npad_q <= (width_q > len) ? (width_q - len) : 7'h0;
			tot_q  <= (width_q > len) ? width_q : len;
		end
		if (cmd.emit) begin
			out_char_q <= char_d;
			out_last_q <= tot_q == 7'd1;
			tot_q      <= tot_q - 7'd1;
			if (cmd.sel == SEL_PAD) npad_q <= npad_q - 7'd1;
			if (cmd.sel == SEL_DIGIT) begin
				for (int i = 0; i < VALUE_BITS - 1; i++) stk_q[i] <= stk_q[i+1];
				ndig_q <= ndig_q - DW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.bit_last  = bcnt_q == BW'(VALUE_BITS - 1);
	assign st.quot_zero = mag_q == '0;
	assign st.pad_zero  = npad_q == 7'h0;
	assign st.has_sign  = has_sign_q;
	assign st.left      = left_q;
	assign st.dig_one   = ndig_q == DW'(1);
	assign st.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/integer_to_ascii_radix_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter
// formats one integer per item as a run of ascii characters, last one marked
// ----------------------------------------------------------------------------
// channel  direction  payload
// s_*      in         operation, value, radix, case, plus, justify, width, pad
// m_*      out        out_char in tdata, last in tlast
//
// an item is accepted; for each digit the divider then steps through every
// bit of the value and the digit is pushed; a prep step follows, then one
// character is sent per cycle while the output does not stall, plus a sign
// step when there is no sign and a step closing the padding
// reset clears the sequencer and the output valid only
// a stalled output holds the sequencer; the next item is taken once the last
// character sits in the output register
module integer_to_ascii_radix_formatter #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_WIDTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[0], value[32:1], radix[37:33], hex_lower[38], show_plus[39],
	// left_justify[40], field_width[47:41], pad_char[55:48]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_char[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);
	import itoa_pkg::*;

	cmd_t    cmd;
	status_t st;

	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	itoa_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.st       (st),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`include "assert_macros.svh"

	// the block is not ready again in the cycle right after taking an item
	`ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready |=> !s_tready), "ready right after accept")
	// only the final character of a number may wait while a new item is taken
	`ASSERT_NEVER(a_idle_only_after_last, (m_tvalid && !m_tlast), s_tready, "idle mid-number")

endmodule

// ===== sim/itoa_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_tb_pkg
// request layout and operation codes shared by the formatter testbench files
// ----------------------------------------------------------------------------
package itoa_tb_pkg;

	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED   = 1'b1;

	// same bit layout as s_tdata, last field in the lowest bits
	typedef struct packed {
		logic [7:0]  pad_char;
		logic [6:0]  field_width;
		logic        left_justify;
		logic        show_plus;
		logic        hex_lower;
		logic [4:0]  radix;
		logic [31:0] value;
		logic        operation;
	} format_req_t;

endpackage

// ===== sim/format_checker.sv =====
// ----------------------------------------------------------------------------
// format_checker
// watches both streams of the radix formatter, builds the expected character
// string for every number taken in and compares each character sent out
// ----------------------------------------------------------------------------
module format_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          chars_pending,
	output int          numbers_taken,
	output int          chars_checked,
	output int          negatives_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import itoa_pkg::*;
	import itoa_tb_pkg::*;

	localparam int FIELD_LIMIT = 64;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	char_item_t expected_chars[$];

	initial begin
		fail_count = 0;
		chars_pending = 0;
		numbers_taken = 0;
		chars_checked = 0;
		negatives_seen = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// expected character string for one number
	function automatic void expand_number(input format_req_t req);
		logic [31:0] mag;
		logic [31:0] base;
		logic [7:0]  sign_byte;
		logic [7:0]  body[$];
		string       digit_set;
		int          width;
		int          npad;
		int          total;
		int          k;
		char_item_t  item;
		base = (req.radix < 5'd2) ? 32'd2 : (req.radix > 5'd16) ? 32'd16 : 32'(req.radix);
		width = (req.field_width > 7'(FIELD_LIMIT)) ? FIELD_LIMIT : int'(req.field_width);
		digit_set = req.hex_lower ? "0123456789abcdef" : "0123456789ABCDEF";
		mag = req.value;
		sign_byte = 8'h00;
		if (req.operation == OP_SIGNED && req.value[31]) begin
			// wraps to 2^31 for the most negative value, which is what we want
			mag = 32'd0 - req.value;
			sign_byte = ASCII_MINUS;
			negatives_seen++;
		end else if (req.show_plus) begin
			sign_byte = ASCII_PLUS;
		end
		do begin
			body.push_front(digit_set[int'(mag % base)]);
			mag = mag / base;
		end while (mag != 32'd0);
		if (sign_byte != 8'h00) begin
			body.push_front(sign_byte);
		end
		npad = (body.size() < width) ? width - body.size() : 0;
		total = body.size() + npad;
		k = 0;
		if (!req.left_justify) begin
			repeat (npad) begin
				item.ch = req.pad_char;
				item.last = (k == total - 1);
				expected_chars.push_back(item);
				k++;
			end
		end
		foreach (body[i]) begin
			item.ch = body[i];
			item.last = (k == total - 1);
			expected_chars.push_back(item);
			k++;
		end
		if (req.left_justify) begin
			repeat (npad) begin
				item.ch = req.pad_char;
				item.last = (k == total - 1);
				expected_chars.push_back(item);
				k++;
			end
		end
	endfunction

	always @(posedge clk) begin : watch
		char_item_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %02h with no number pending", m_tdata));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.ch) begin
						report_mismatch($sformatf("char %02h, expected %02h", m_tdata, want.ch));
					end
					if (m_tlast !== want.last) begin
						report_mismatch($sformatf("last %b, expected %b on char %02h",
							m_tlast, want.last, want.ch));
					end
					chars_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				expand_number(format_req_t'(s_tdata));
				numbers_taken++;
			end
		end
		chars_pending = expected_chars.size();
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stimulus for the radix formatter: a directed set of edge cases, then random
// numbers and format options, sent in bursts against a stalling receiver
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import itoa_tb_pkg::*;

	localparam int         RANDOM_ITEMS = 210;
	localparam logic [7:0] PAD_SPACE    = 8'h20;
	localparam logic [7:0] PAD_ZERO     = 8'h30;
	localparam logic [7:0] PAD_STAR     = 8'h2A;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int fail_count;
	int chars_pending;
	int numbers_taken;
	int chars_checked;
	int negatives_seen;

	int burst_left;
	bit sender_gappy;

	integer_to_ascii_radix_formatter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	format_checker char_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.chars_pending  (chars_pending),
		.numbers_taken  (numbers_taken),
		.chars_checked  (chars_checked),
		.negatives_seen (negatives_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("[integer_to_ascii_radix_formatter] ERROR");
		$finish;
	end

	function automatic format_req_t make_request(input logic op, input logic [31:0] value,
		input logic [4:0] radix, input logic lower, input logic plus, input logic left,
		input logic [6:0] width, input logic [7:0] pad);
		format_req_t r;
		r.operation = op;
		r.value = value;
		r.radix = radix;
		r.hex_lower = lower;
		r.show_plus = plus;
		r.left_justify = left;
		r.field_width = width;
		r.pad_char = pad;
		return r;
	endfunction

	function automatic format_req_t random_request();
		format_req_t r;
		r.operation = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: r.value = $urandom();
			5, 6:          r.value = 32'($urandom_range(0, 40));
			7:             r.value = 32'd0 - 32'($urandom_range(1, 40));
			8: begin
				case ($urandom_range(0, 4))
					0: r.value = 32'h0000_0000;
					1: r.value = 32'h0000_0001;
					2: r.value = 32'h7FFF_FFFF;
					3: r.value = 32'h8000_0000;
					default: r.value = 32'hFFFF_FFFF;
				endcase
			end
			default: r.value = $urandom() >> $urandom_range(0, 31);
		endcase
		// mostly legal bases, now and then the whole field range
		if ($urandom_range(0, 19) < 17) begin
			r.radix = 5'($urandom_range(2, 16));
		end else begin
			r.radix = 5'($urandom_range(0, 31));
		end
		r.hex_lower = 1'($urandom_range(0, 1));
		r.show_plus = 1'($urandom_range(0, 1));
		r.left_justify = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 7) == 0) begin
			r.field_width = 7'($urandom_range(0, 127));
		end else begin
			r.field_width = 7'($urandom_range(0, 24));
		end
		case ($urandom_range(0, 3))
			0:       r.pad_char = PAD_SPACE;
			1:       r.pad_char = PAD_ZERO;
			default: r.pad_char = 8'($urandom_range(0, 255));
		endcase
		return r;
	endfunction

	// one item, preceded by a random gap when a new burst starts in a gappy stretch
	task automatic send_number(input format_req_t req);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = sender_gappy ? $urandom_range(0, 6) : 0;
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// receiver: changing stall patterns, plus two long hold-offs
	initial begin : receiver
		int mode;
		int seg;
		int period;
		int rx_cycles;
		int hold_left;
		m_tready = 1'b0;
		rx_cycles = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(20, 300);
			period = $urandom_range(2, 5);
			repeat (seg) begin
				@(negedge clk);
				rx_cycles++;
				if (rx_cycles == 2000 || rx_cycles == 50000) begin
					hold_left = 1500;
				end
				if (hold_left > 0) begin
					hold_left--;
					m_tready <= 1'b0;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= ($urandom_range(0, 9) < 7);
						2: m_tready <= ($urandom_range(0, 9) < 3);
						default: m_tready <= (rx_cycles % period == 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		burst_left = 0;
		sender_gappy = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero, full ranges, sign handling
		send_number(make_request(OP_UNSIGNED, 32'h0000_0000, 5'd10, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'h8000_0000, 5'd10, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'h8000_0000, 5'd2, 1'b0, 1'b1, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'hFFFF_FFFF, 5'd16, 1'b0, 1'b1, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'h0000_0000, 5'd10, 1'b0, 1'b1, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'h7FFF_FFFF, 5'd10, 1'b0, 1'b1, 1'b0, 7'd0, PAD_SPACE));
		// unsigned value with its top bit set still gets a plus
		send_number(make_request(OP_UNSIGNED, 32'h8000_0001, 5'd10, 1'b0, 1'b1, 1'b0, 7'd0, PAD_SPACE));
		// letter case
		send_number(make_request(OP_UNSIGNED, 32'hDEAD_BEEF, 5'd16, 1'b1, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'hDEAD_BEEF, 5'd16, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'hFFFF_FFFF, 5'd15, 1'b1, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'hFFFF_FFFF, 5'd3, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		// bases out of range clamp to two and sixteen
		send_number(make_request(OP_UNSIGNED, 32'd5, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'd6, 5'd1, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'hABCD_EF01, 5'd31, 1'b1, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'hFFFF_FF00, 5'd17, 1'b0, 1'b0, 1'b0, 7'd0, PAD_SPACE));
		// widths: saturation, exact fit, too narrow
		send_number(make_request(OP_UNSIGNED, 32'd1234, 5'd10, 1'b0, 1'b0, 1'b0, 7'd127, PAD_STAR));
		send_number(make_request(OP_SIGNED, 32'hFFFF_FFD6, 5'd10, 1'b0, 1'b0, 1'b1, 7'd64, PAD_SPACE));
		send_number(make_request(OP_SIGNED, 32'd77, 5'd8, 1'b0, 1'b1, 1'b1, 7'd65, PAD_SPACE));
		send_number(make_request(OP_UNSIGNED, 32'd99999, 5'd10, 1'b0, 1'b0, 1'b0, 7'd3, PAD_STAR));
		send_number(make_request(OP_SIGNED, 32'hFFFF_FF85, 5'd16, 1'b0, 1'b0, 1'b0, 7'd3, PAD_STAR));
		// zero byte pad goes in front of the sign, all-ones pad after
		send_number(make_request(OP_SIGNED, 32'hFFFF_FFF9, 5'd10, 1'b0, 1'b0, 1'b0, 7'd10, 8'h00));
		send_number(make_request(OP_UNSIGNED, 32'd255, 5'd16, 1'b1, 1'b1, 1'b1, 7'd9, 8'hFF));
		send_number(make_request(OP_UNSIGNED, 32'd0, 5'd2, 1'b0, 1'b0, 1'b1, 7'd1, PAD_ZERO));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// alternate stretches of gappy and back-to-back sending
			if (n % 40 == 0) begin
				sender_gappy = ~sender_gappy;
			end
			send_number(random_request());
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (chars_pending != 0);
		repeat (40) @(negedge clk);

		$display("covered %0d numbers (%0d negative) as %0d characters, signed and unsigned,",
			numbers_taken, negatives_seen, chars_checked);
		$display("bases and widths beyond range, both justifications, stalls on either side");
		if (fail_count == 0) begin
			$display("[integer_to_ascii_radix_formatter] OK");
		end else begin
			$display("[integer_to_ascii_radix_formatter] ERROR");
		end
		$finish;
	end

endmodule
